// File: design/rayang_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rayang_pkg: shared types and constants for the ray angle block
// Holds the fixed widths, the atan table in turns, the output scale factors
// and the word types that travel along the pipeline.
// ----------------------------------------------------------------------------
package rayang_pkg;

  // fixed widths
  localparam int unsigned CALC_W       = 64;  // signed width of products and cordic x/y
  localparam int unsigned TURN_W       = 32;  // angle accumulator, 2^-32 turn
  localparam int unsigned DIFF_KEEP_W  = 29;  // coordinate width above which diffs are shifted
  localparam int unsigned TOL_W        = 40;
  localparam int unsigned SNAP_TOL_W   = 16;
  localparam int unsigned CFG_DATA_W   = 40;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned OUT_W        = 25;
  localparam int unsigned OUT_TDATA_W  = 32;
  localparam int unsigned POINT_FIELDS = 6;

  // pipeline depths of the fixed parts
  localparam int unsigned FRONT_STAGES = 4;
  localparam int unsigned NORM_STEPS   = 6;
  localparam int unsigned NORM_LEAD    = 59;  // normalize until magnitude reaches 2^(NORM_LEAD-1)
  localparam int unsigned BACK_STAGES  = 3;
  localparam int unsigned TABLE_LEN    = 40;

  // special angles in turns
  localparam logic [TURN_W-1:0] TURN_ZERO    = 32'h0000_0000;
  localparam logic [TURN_W-1:0] TURN_QUARTER = 32'h4000_0000;
  localparam logic [TURN_W-1:0] TURN_HALF    = 32'h8000_0000;
  localparam logic [TURN_W-1:0] TURN_3QUART  = 32'hC000_0000;

  // turns to output units
  localparam logic [TURN_W-1:0] DEG_SCALE = 32'd360;
  localparam logic [TURN_W-1:0] RAD_SCALE = 32'd1686629713;  // 2*pi, 28 fraction bits
  localparam int unsigned       DEG_SHIFT = 16;
  localparam int unsigned       RAD_SHIFT = 44;
  localparam logic [CALC_W-1:0] DEG_ROUND = 64'd1 << (DEG_SHIFT - 1);
  localparam logic [CALC_W-1:0] RAD_ROUND = 64'd1 << (RAD_SHIFT - 1);

  localparam int unsigned       SNAP_COUNT = 4;
  localparam logic [OUT_W-1:0]  SNAP_POINTS [SNAP_COUNT] = '{
    25'd5898240, 25'd11796480, 25'd17694720, 25'd23592960
  };
  localparam logic [OUT_W-1:0]  ANGLE_MAX = 25'd23592960;

  localparam logic [TURN_W-1:0] ATAN_TURNS [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANGLE_DEG = 2'd0,
    CFG_ZERO_TOL  = 2'd1,
    CFG_SNAP_TOL  = 2'd2
  } cfg_reg_e;

  // one word in the rotation chain
  typedef struct packed {
    logic                     bypass;  // angle already final, cells leave z alone
    logic signed [CALC_W-1:0] x;
    logic signed [CALC_W-1:0] y;
    logic [TURN_W-1:0]        z;
  } cordic_t;

  // word in the normalizer, with the or of both magnitudes
  typedef struct packed {
    cordic_t           tok;
    logic [CALC_W-1:0] mag;
  } norm_t;

endpackage

// File: design/rayang_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rayang_front: ray differences, dot and cross products, classification
// Four stages: differences, products, sums, then the zero test, axis cases
// and the fold of the left half plane onto the right.
// ----------------------------------------------------------------------------
module rayang_front import rayang_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 20
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          en_o,
  input  logic signed [COORD_WIDTH-1:0] first_x_i,
  input  logic signed [COORD_WIDTH-1:0] first_y_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_x_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_y_i,
  input  logic signed [COORD_WIDTH-1:0] second_x_i,
  input  logic signed [COORD_WIDTH-1:0] second_y_i,
  input  logic [TOL_W-1:0]              zero_tol_i,
  output logic                          valid_o,
  output norm_t                         data_o,
  input  logic                          en_i
);

  localparam int unsigned DROP = (COORD_WIDTH > DIFF_KEEP_W) ? COORD_WIDTH - DIFF_KEEP_W : 0;
  localparam int unsigned DW   = COORD_WIDTH + 1 - DROP;
  localparam int unsigned PW   = 2 * DW;
  localparam int unsigned SW   = PW + 1;

  logic [FRONT_STAGES-1:0] vld_q;
  logic [FRONT_STAGES-1:0] en;

  // diff order: ax, ay, bx, by
  logic signed [COORD_WIDTH:0] sub   [4];
  logic signed [COORD_WIDTH:0] subsh [4];
  logic signed [DW-1:0]        diff_d [4];
  logic signed [DW-1:0]        diff_q [4];
  // product order: ax*bx, ay*by, ax*by, ay*bx
  logic signed [PW-1:0]        prod_d [4];
  logic signed [PW-1:0]        prod_q [4];
  logic signed [SW-1:0]        dot_d, crs_d, dot_q, crs_q;
  logic signed [CALC_W-1:0]    dot_w, crs_w;
  logic [CALC_W-1:0]           mag_dot, mag_crs;
  logic                        zero_hit;
  norm_t                       data_d, data_q;

  always_comb begin
    en[FRONT_STAGES-1] = ~vld_q[FRONT_STAGES-1] | en_i;
    for (int k = FRONT_STAGES - 2; k >= 0; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
  end

  assign en_o    = en[0];
  assign valid_o = vld_q[FRONT_STAGES-1];
  assign data_o  = data_q;

  // stage 0: ray differences, narrowed for very wide coordinates
  always_comb begin
    sub[0] = {first_x_i[COORD_WIDTH-1], first_x_i} - {vertex_x_i[COORD_WIDTH-1], vertex_x_i};
    sub[1] = {first_y_i[COORD_WIDTH-1], first_y_i} - {vertex_y_i[COORD_WIDTH-1], vertex_y_i};
    sub[2] = {second_x_i[COORD_WIDTH-1], second_x_i} - {vertex_x_i[COORD_WIDTH-1], vertex_x_i};
    sub[3] = {second_y_i[COORD_WIDTH-1], second_y_i} - {vertex_y_i[COORD_WIDTH-1], vertex_y_i};
    for (int k = 0; k < 4; k++) begin
      subsh[k]  = sub[k] >>> DROP;
      diff_d[k] = subsh[k][DW-1:0];
    end
  end

  // stage 1: four products
  always_comb begin
    prod_d[0] = diff_q[0] * diff_q[2];
    prod_d[1] = diff_q[1] * diff_q[3];
    prod_d[2] = diff_q[0] * diff_q[3];
    prod_d[3] = diff_q[1] * diff_q[2];
  end

  // stage 2: dot and cross
  always_comb begin
    dot_d = $signed({prod_q[0][PW-1], prod_q[0]}) + $signed({prod_q[1][PW-1], prod_q[1]});
    crs_d = $signed({prod_q[2][PW-1], prod_q[2]}) - $signed({prod_q[3][PW-1], prod_q[3]});
  end

  // stage 3: zero test, axis cases, fold into the right half plane
  always_comb begin
    dot_w    = {{(CALC_W-SW){dot_q[SW-1]}}, dot_q};
    crs_w    = {{(CALC_W-SW){crs_q[SW-1]}}, crs_q};
    mag_dot  = dot_w[CALC_W-1] ? -dot_w : dot_w;
    mag_crs  = crs_w[CALC_W-1] ? -crs_w : crs_w;
    zero_hit = (mag_dot < CALC_W'(zero_tol_i)) && (mag_crs < CALC_W'(zero_tol_i));

    data_d.mag        = mag_dot | mag_crs;
    data_d.tok.bypass = 1'b0;
    data_d.tok.x      = mag_dot;
    data_d.tok.y      = dot_w[CALC_W-1] ? -crs_w : crs_w;
    data_d.tok.z      = dot_w[CALC_W-1] ? TURN_HALF : TURN_ZERO;
    if (zero_hit) begin
      data_d.tok.bypass = 1'b1;
      data_d.tok.z      = TURN_ZERO;
    end else if (crs_w == '0) begin
      data_d.tok.bypass = 1'b1;
    end else if (dot_w == '0) begin
      data_d.tok.bypass = 1'b1;
      data_d.tok.z      = crs_w[CALC_W-1] ? TURN_3QUART : TURN_QUARTER;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= valid_i;
      end
      for (int k = 1; k < FRONT_STAGES; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      diff_q <= diff_d;
    end
    if (en[1]) begin
      prod_q <= prod_d;
    end
    if (en[2]) begin
      dot_q <= dot_d;
      crs_q <= crs_d;
    end
    if (en[3]) begin
      data_q <= data_d;
    end
  end

endmodule

// File: design/rayang_norm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rayang_norm_cell: one step of the leading-bit normalizer
// Doubles x and y SHIFT times over when the larger magnitude is still short
// enough; six cells with shifts 32 down to 1 bring it to 2^58.
// ----------------------------------------------------------------------------
module rayang_norm_cell import rayang_pkg::*; #(
  parameter int unsigned SHIFT = 1
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  norm_t data_i,
  output logic  en_o,
  output logic  valid_o,
  output norm_t data_o,
  input  logic  en_i
);

  logic  vld_q;
  norm_t data_d, data_q;

  assign en_o    = ~vld_q | en_i;
  assign valid_o = vld_q;
  assign data_o  = data_q;

  always_comb begin
    data_d = data_i;
    if (data_i.mag < (CALC_W'(1) << (NORM_LEAD - SHIFT))) begin
      data_d.mag   = data_i.mag << SHIFT;
      data_d.tok.x = data_i.tok.x <<< SHIFT;
      data_d.tok.y = data_i.tok.y <<< SHIFT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      data_q <= data_d;
    end
  end

endmodule

// File: design/rayang_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rayang_cordic_cell: one vectoring rotation of the cordic chain
// Rotates (x, y) toward the x axis by atan(2^-IDX) and adds or subtracts the
// matching turn fraction to or from z; words marked bypass pass through unchanged.
// ----------------------------------------------------------------------------
module rayang_cordic_cell import rayang_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  cordic_t data_i,
  output logic    en_o,
  output logic    valid_o,
  output cordic_t data_o,
  input  logic    en_i
);

  logic                     vld_q;
  cordic_t                  data_d, data_q;
  logic signed [CALC_W-1:0] x_in, y_in, xs, ys;

  assign en_o    = ~vld_q | en_i;
  assign valid_o = vld_q;
  assign data_o  = data_q;

  always_comb begin
    data_d = data_i;
    x_in   = data_i.x;
    y_in   = data_i.y;
    xs     = x_in >>> IDX;
    ys     = y_in >>> IDX;
    if (!data_i.bypass) begin
      if (!y_in[CALC_W-1]) begin
        data_d.x = x_in + ys;
        data_d.y = y_in - xs;
        data_d.z = data_i.z + ATAN_TURNS[IDX];
      end else begin
        data_d.x = x_in - ys;
        data_d.y = y_in + xs;
        data_d.z = data_i.z - ATAN_TURNS[IDX];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      data_q <= data_d;
    end
  end

endmodule

// File: design/rayang_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rayang_back: turns to output units, rounding and snapping
// Three stages: scale multiply, round and shift, snap to the quarter-turn
// points of degree mode; the last stage is the output register.
// ----------------------------------------------------------------------------
module rayang_back import rayang_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [TURN_W-1:0]     turns_i,
  output logic                  en_o,
  input  logic                  deg_i,
  input  logic [SNAP_TOL_W-1:0] snap_tol_i,
  output logic                  valid_o,
  output logic [OUT_W-1:0]      angle_o,
  input  logic                  en_i
);

  logic [BACK_STAGES-1:0] vld_q;
  logic [BACK_STAGES-1:0] en;

  logic [TURN_W-1:0] coef;
  logic [CALC_W-1:0] prod_d, prod_q;
  logic [CALC_W-1:0] rsum, rshift;
  logic [OUT_W-1:0]  val_d, val_q;
  logic [OUT_W-1:0]  snap_d, snap_q;

  always_comb begin
    en[BACK_STAGES-1] = ~vld_q[BACK_STAGES-1] | en_i;
    for (int k = BACK_STAGES - 2; k >= 0; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
  end

  assign en_o    = en[0];
  assign valid_o = vld_q[BACK_STAGES-1];
  assign angle_o = snap_q;

  always_comb begin
    coef   = deg_i ? DEG_SCALE : RAD_SCALE;
    prod_d = CALC_W'(turns_i) * CALC_W'(coef);
  end

  // round half up
  always_comb begin
    rsum   = prod_q + (deg_i ? DEG_ROUND : RAD_ROUND);
    rshift = deg_i ? (rsum >> DEG_SHIFT) : (rsum >> RAD_SHIFT);
    val_d  = rshift[OUT_W-1:0];
  end

  // each snap point is tried against the value left by the one before
  always_comb begin
    logic [OUT_W-1:0] gap;
    snap_d = val_q;
    for (int k = 0; k < SNAP_COUNT; k++) begin
      gap = (snap_d > SNAP_POINTS[k]) ? snap_d - SNAP_POINTS[k] : SNAP_POINTS[k] - snap_d;
      if (gap < OUT_W'(snap_tol_i)) begin
        snap_d = SNAP_POINTS[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= valid_i;
      end
      for (int k = 1; k < BACK_STAGES; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      prod_q <= prod_d;
    end
    if (en[1]) begin
      val_q <= val_d;
    end
    if (en[2]) begin
      snap_q <= snap_d;
    end
  end

endmodule

// File: design/ray_angle_2d_atan2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_angle_2d_atan2: counterclockwise angle between two rays in 2D
// Dot and cross products of the rays, pipelined cordic atan2 in turns,
// scaling to radians or degrees and, in degrees, snapping to quarter-turn points.
// ----------------------------------------------------------------------------
// channel   dir  handshake                     content
// s_axis    in   s_axis_tvalid/s_axis_tready   three points, 6 x COORD_WIDTH bits
// m_axis    out  m_axis_tvalid/m_axis_tready   swept_angle, 25 bits, 16 fraction bits
// cfg       in   cfg_we_i (no wait)            register index and value
//
// one word per cycle in and out while the output is not stalled by m_axis_tready
// (4 front stages, 6 normalizer cells, one cordic cell per stage up to 40, 3 back stages)
// every stage holds its word only while the stage after it is full and
// stalled, so bubbles close up and input keeps flowing into empty stages
// reset clears all valid flags and the three configuration registers
// ----------------------------------------------------------------------------
module ray_angle_2d_atan2 import rayang_pkg::*; #(
  parameter int unsigned COORD_WIDTH   = 20,
  parameter int unsigned CORDIC_STAGES = 24
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  // first_x, first_y, vertex_x, vertex_y, second_x, second_y
  input  logic [((POINT_FIELDS*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  logic                                        s_axis_tvalid,
  output logic                                        s_axis_tready,
  // swept_angle
  output logic [OUT_TDATA_W-1:0]                      m_axis_tdata,
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  input  logic                                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                        cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]                       cfg_data_i
);

  localparam int unsigned CELLS      = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam int unsigned PIPE_DEPTH = FRONT_STAGES + NORM_STEPS + CELLS + BACK_STAGES;

  logic                  deg_q;
  logic [TOL_W-1:0]      zero_tol_q;
  logic [SNAP_TOL_W-1:0] snap_tol_q;

  logic signed [COORD_WIDTH-1:0] first_x, first_y, vertex_x, vertex_y, second_x, second_y;

  norm_t   norm_dat [NORM_STEPS+1];
  logic    norm_vld [NORM_STEPS+1];
  logic    norm_en  [NORM_STEPS+1];
  cordic_t cor_dat  [CELLS+1];
  logic    cor_vld  [CELLS+1];
  logic    cor_en   [CELLS+1];
  logic [OUT_W-1:0] angle;

  assign first_x  = s_axis_tdata[0*COORD_WIDTH +: COORD_WIDTH];
  assign first_y  = s_axis_tdata[1*COORD_WIDTH +: COORD_WIDTH];
  assign vertex_x = s_axis_tdata[2*COORD_WIDTH +: COORD_WIDTH];
  assign vertex_y = s_axis_tdata[3*COORD_WIDTH +: COORD_WIDTH];
  assign second_x = s_axis_tdata[4*COORD_WIDTH +: COORD_WIDTH];
  assign second_y = s_axis_tdata[5*COORD_WIDTH +: COORD_WIDTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_q      <= 1'b0;
      zero_tol_q <= '0;
      snap_tol_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ANGLE_DEG: deg_q      <= cfg_data_i[0];
        CFG_ZERO_TOL:  zero_tol_q <= cfg_data_i[TOL_W-1:0];
        CFG_SNAP_TOL:  snap_tol_q <= cfg_data_i[SNAP_TOL_W-1:0];
        default: ;
      endcase
    end
  end

  rayang_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s_axis_tvalid),
    .en_o       (s_axis_tready),
    .first_x_i  (first_x),
    .first_y_i  (first_y),
    .vertex_x_i (vertex_x),
    .vertex_y_i (vertex_y),
    .second_x_i (second_x),
    .second_y_i (second_y),
    .zero_tol_i (zero_tol_q),
    .valid_o    (norm_vld[0]),
    .data_o     (norm_dat[0]),
    .en_i       (norm_en[0])
  );

  for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
    rayang_norm_cell #(
      .SHIFT(1 << (NORM_STEPS - 1 - k))
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (norm_vld[k]),
      .data_i  (norm_dat[k]),
      .en_o    (norm_en[k]),
      .valid_o (norm_vld[k+1]),
      .data_o  (norm_dat[k+1]),
      .en_i    (norm_en[k+1])
    );
  end

  assign cor_dat[0]          = norm_dat[NORM_STEPS].tok;
  assign cor_vld[0]          = norm_vld[NORM_STEPS];
  assign norm_en[NORM_STEPS] = cor_en[0];

  for (genvar k = 0; k < CELLS; k++) begin : g_cordic
    rayang_cordic_cell #(
      .IDX(k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cor_vld[k]),
      .data_i  (cor_dat[k]),
      .en_o    (cor_en[k]),
      .valid_o (cor_vld[k+1]),
      .data_o  (cor_dat[k+1]),
      .en_i    (cor_en[k+1])
    );
  end

  rayang_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (cor_vld[CELLS]),
    .turns_i    (cor_dat[CELLS].z),
    .en_o       (cor_en[CELLS]),
    .deg_i      (deg_q),
    .snap_tol_i (snap_tol_q),
    .valid_o    (m_axis_tvalid),
    .angle_o    (angle),
    .en_i       (m_axis_tready)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-OUT_W){1'b0}}, angle};

endmodule

// File: design/rayang_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rayang_checker: port-level checks for the ray angle block
// Counts words in flight from the two handshakes and checks flow, capacity,
// the ready rule and the range of the result.
// ----------------------------------------------------------------------------
module rayang_checker import rayang_pkg::*; #(
  parameter int unsigned DEPTH = 37
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 2);

  logic [CNT_W-1:0] cnt_q;
  logic             take_in, take_out;

  assign take_in  = s_axis_tvalid & s_axis_tready;
  assign take_out = m_axis_tvalid & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (take_in && !take_out) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end else if (take_out && !take_in) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:OUT_W] == '0 &&
                      m_axis_tdata[OUT_W-1:0] <= ANGLE_MAX)
    else $error("result out of range");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cnt_q != '0)
    else $error("result without a word in flight");

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("more words in flight than pipeline stages");

  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while output not blocked");

endmodule

bind ray_angle_2d_atan2 rayang_checker #(
  .DEPTH(PIPE_DEPTH)
) u_rayang_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
